@@ rtl/core/yuyv2rgb_pkg.sv @@
package yuyv2rgb_pkg;

	localparam int MaxWidth  = 4096;
	localparam int MaxHeight = 4096;

	localparam int PixW    = 8;
	localparam int CfgW    = 13;
	localparam int CfgIdxW = 3;
	localparam int PairsW  = $clog2(MaxWidth / 2 + 1);
	localparam int HeightW = $clog2(MaxHeight + 1);
	localparam int ColW    = $clog2(MaxWidth / 2);
	localparam int RowW    = $clog2(MaxHeight);
	localparam int OffsetW = 26;
	localparam int SumW    = 20;

	localparam logic signed [SumW-1:0] CoefY     = SumW'(298);
	localparam logic signed [SumW-1:0] CoefRv    = SumW'(409);
	localparam logic signed [SumW-1:0] CoefGu    = SumW'(100);
	localparam logic signed [SumW-1:0] CoefGv    = SumW'(208);
	localparam logic signed [SumW-1:0] CoefBu    = SumW'(516);
	localparam logic signed [SumW-1:0] Round     = SumW'(128);
	localparam logic signed [SumW-1:0] LumaBase  = SumW'(16);
	localparam logic signed [SumW-1:0] ChromaMid = SumW'(128);
	localparam logic [PixW-1:0]        AlphaOpaque = 8'hFF;

	typedef enum logic [CfgIdxW-1:0] {
		RegFrameWidth  = 3'd0,
		RegFrameHeight = 3'd1,
		RegAlphaIn     = 3'd2,
		RegAlphaOut    = 3'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [PairsW-1:0]  pairs;
		logic [HeightW-1:0] height;
		logic               alpha_in;
		logic               alpha_out;
	} frame_cfg_t;

	function automatic logic [PixW-1:0] clamp_pix(input logic signed [SumW-1:0] v);
		logic [PixW-1:0] r;
		if (v[SumW-1]) begin
			r = '0;
		end else if (|v[SumW-2:PixW+8]) begin
			r = AlphaOpaque;
		end else begin
			r = v[PixW+7:8];
		end
		return r;
	endfunction

endpackage

@@ rtl/core/yuyv2rgb_lane.sv @@
module yuyv2rgb_lane (
	input  logic                                   clk,
	input  logic                                   en,
	input  logic [yuyv2rgb_pkg::PixW-1:0]          luma_s1,
	input  logic signed [yuyv2rgb_pkg::SumW-1:0]   red_term_s2,
	input  logic signed [yuyv2rgb_pkg::SumW-1:0]   green_term_s2,
	input  logic signed [yuyv2rgb_pkg::SumW-1:0]   blue_term_s2,
	output logic [yuyv2rgb_pkg::PixW-1:0]          red,
	output logic [yuyv2rgb_pkg::PixW-1:0]          green,
	output logic [yuyv2rgb_pkg::PixW-1:0]          blue
);
	import yuyv2rgb_pkg::*;

	logic signed [SumW-1:0] luma_c;
	logic signed [SumW-1:0] luma_term_s2;

	assign luma_c = $signed(SumW'(luma_s1)) - LumaBase;

	always_ff @(posedge clk) begin
		if (en) begin
			luma_term_s2 <= luma_c * CoefY;
		end
	end

	assign red   = clamp_pix(luma_term_s2 + red_term_s2);
	assign green = clamp_pix(luma_term_s2 + green_term_s2);
	assign blue  = clamp_pix(luma_term_s2 + blue_term_s2);

endmodule

@@ rtl/core/yuyv2rgb_addr.sv @@
module yuyv2rgb_addr (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 en,
	input  logic                                 fire,
	input  yuyv2rgb_pkg::frame_cfg_t             cfg,
	output logic [yuyv2rgb_pkg::OffsetW-1:0]     offset,
	output logic                                 last_pair
);
	import yuyv2rgb_pkg::*;

	localparam int RowProdW = RowW + PairsW + 1;

	logic [ColW-1:0]       col_q;
	logic [RowW-1:0]       row_q;
	logic [ColW-1:0]       col_use;
	logic [RowW-1:0]       row_use;
	logic                  col_last;
	logic                  row_last;
	logic [RowW-1:0]       rowrev;
	logic [PairsW:0]       width;

	logic [ColW-1:0]       col_s1;
	logic [RowW-1:0]       rowrev_s1;
	logic                  last_s1;
	logic [RowProdW-1:0]   row_prod_s2;
	logic [ColW+2:0]       col_part_s2;
	logic                  last_s2;
	logic [RowProdW+1:0]   row_scaled;

	assign col_use  = (PairsW'(col_q) >= cfg.pairs) ? '0 : col_q;
	assign row_use  = (HeightW'(row_q) >= cfg.height) ? '0 : row_q;
	assign col_last = (PairsW'(col_use) == cfg.pairs - PairsW'(1));
	assign row_last = (HeightW'(row_use) == cfg.height - HeightW'(1));
	assign rowrev   = RowW'(cfg.height - HeightW'(1) - HeightW'(row_use));
	assign width    = {cfg.pairs, 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (fire) begin
			if (col_last) begin
				col_q <= '0;
				row_q <= row_last ? '0 : row_use + RowW'(1);
			end else begin
				col_q <= col_use + ColW'(1);
				row_q <= row_use;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			col_s1      <= col_use;
			rowrev_s1   <= rowrev;
			last_s1     <= col_last && row_last;
			row_prod_s2 <= RowProdW'(rowrev_s1) * RowProdW'(width);
			col_part_s2 <= cfg.alpha_out ? {col_s1, 3'b000}
				: ({1'b0, col_s1, 2'b00} + {2'b00, col_s1, 1'b0});
			last_s2     <= last_s1;
		end
	end

	assign row_scaled = cfg.alpha_out ? {row_prod_s2, 2'b00}
		: ({1'b0, row_prod_s2, 1'b0} + {2'b00, row_prod_s2});
	assign offset     = OffsetW'(row_scaled) + OffsetW'(col_part_s2);
	assign last_pair  = last_s2;

endmodule

@@ rtl/core/yuyv_to_rgb_converter_top.sv @@
// yuyv to rgb converter, integer bt.601, one macropixel (two pixels) per transfer
//
// input channel: in_valid / in_stall with luma_first, chroma_blue, luma_second,
// chroma_red and two optional alpha bytes. output channel: out_valid / out_stall
// with both rgb(a) pixels, the byte offset of the pair in a bottom-up frame and
// frame_end on the last pair of the frame.
// config channel: cfg_valid / cfg_ready (always ready), cfg_index selects frame
// width, frame height, alpha-in and alpha-out; write only while the block is idle.
//
// pipeline: three register stages (input stage, product stage, output register);
// out_valid rises when a transfer reaches the output register. throughput: one
// macropixel per cycle unless out_stall holds the pipeline, set by two parallel
// pixel lanes that each finish a pixel per cycle.
// when the output register holds a result and out_stall is high, the whole
// pipeline holds and in_stall rises in the same cycle; nothing is dropped.
// reset clears the valid flags and the row/column counters and loads the default
// frame of 640x480, alpha off; no clearing pass, inputs are taken right away.
module yuyv_to_rgb_converter_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [yuyv2rgb_pkg::PixW-1:0]        luma_first,
	input  logic [yuyv2rgb_pkg::PixW-1:0]        chroma_blue,
	input  logic [yuyv2rgb_pkg::PixW-1:0]        luma_second,
	input  logic [yuyv2rgb_pkg::PixW-1:0]        chroma_red,
	input  logic [yuyv2rgb_pkg::PixW-1:0]        alpha_first_in,
	input  logic [yuyv2rgb_pkg::PixW-1:0]        alpha_second_in,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [yuyv2rgb_pkg::PixW-1:0]        red_first,
	output logic [yuyv2rgb_pkg::PixW-1:0]        green_first,
	output logic [yuyv2rgb_pkg::PixW-1:0]        blue_first,
	output logic [yuyv2rgb_pkg::PixW-1:0]        alpha_first_out,
	output logic [yuyv2rgb_pkg::PixW-1:0]        red_second,
	output logic [yuyv2rgb_pkg::PixW-1:0]        green_second,
	output logic [yuyv2rgb_pkg::PixW-1:0]        blue_second,
	output logic [yuyv2rgb_pkg::PixW-1:0]        alpha_second_out,
	output logic [yuyv2rgb_pkg::OffsetW-1:0]     dest_offset,
	output logic                                 frame_end,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [yuyv2rgb_pkg::CfgIdxW-1:0]     cfg_index,
	input  logic [yuyv2rgb_pkg::CfgW-1:0]        cfg_data
);
	import yuyv2rgb_pkg::*;

	frame_cfg_t             cfg_q;
	logic [CfgW:0]          cfg_wide;
	logic [CfgW:0]          width_eff;
	logic [CfgW:0]          height_eff;

	logic                   en;
	logic                   fire;
	logic                   valid_s1;
	logic                   valid_s2;
	logic                   valid_s3;

	logic [PixW-1:0]        luma_first_s1;
	logic [PixW-1:0]        luma_second_s1;
	logic [PixW-1:0]        cb_s1;
	logic [PixW-1:0]        cr_s1;
	logic [PixW-1:0]        alpha_first_s1;
	logic [PixW-1:0]        alpha_second_s1;
	logic [PixW-1:0]        alpha_first_s2;
	logic [PixW-1:0]        alpha_second_s2;

	logic signed [SumW-1:0] cb_d;
	logic signed [SumW-1:0] cr_e;
	logic signed [SumW-1:0] red_term_s2;
	logic signed [SumW-1:0] green_term_s2;
	logic signed [SumW-1:0] blue_term_s2;

	logic [PixW-1:0]        red_a;
	logic [PixW-1:0]        green_a;
	logic [PixW-1:0]        blue_a;
	logic [PixW-1:0]        red_b;
	logic [PixW-1:0]        green_b;
	logic [PixW-1:0]        blue_b;
	logic [OffsetW-1:0]     offset_s2;
	logic                   last_s2;

	logic [PixW-1:0]        red_first_s3;
	logic [PixW-1:0]        green_first_s3;
	logic [PixW-1:0]        blue_first_s3;
	logic [PixW-1:0]        alpha_first_s3;
	logic [PixW-1:0]        red_second_s3;
	logic [PixW-1:0]        green_second_s3;
	logic [PixW-1:0]        blue_second_s3;
	logic [PixW-1:0]        alpha_second_s3;
	logic [OffsetW-1:0]     offset_s3;
	logic                   frame_end_s3;

	// config: width and height are clamped once, at the write
	assign cfg_ready = 1'b1;
	assign cfg_wide  = {1'b0, cfg_data};

	always_comb begin
		priority if (cfg_wide < (CfgW+1)'(2)) begin
			width_eff = (CfgW+1)'(2);
		end else if (cfg_wide > (CfgW+1)'(MaxWidth)) begin
			width_eff = (CfgW+1)'(MaxWidth);
		end else begin
			width_eff = cfg_wide;
		end
		priority if (cfg_wide < (CfgW+1)'(1)) begin
			height_eff = (CfgW+1)'(1);
		end else if (cfg_wide > (CfgW+1)'(MaxHeight)) begin
			height_eff = (CfgW+1)'(MaxHeight);
		end else begin
			height_eff = cfg_wide;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pairs     <= PairsW'(640 / 2);
			cfg_q.height    <= HeightW'(480);
			cfg_q.alpha_in  <= 1'b0;
			cfg_q.alpha_out <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				RegFrameWidth:  cfg_q.pairs     <= PairsW'(width_eff >> 1);
				RegFrameHeight: cfg_q.height    <= HeightW'(height_eff);
				RegAlphaIn:     cfg_q.alpha_in  <= cfg_data[0];
				RegAlphaOut:    cfg_q.alpha_out <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// pipeline moves as one unless the output register is full and stalled
	assign en       = !valid_s3 || !out_stall;
	assign in_stall = !en;
	assign fire     = in_valid && en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	assign cb_d = $signed(SumW'(cb_s1)) - ChromaMid;
	assign cr_e = $signed(SumW'(cr_s1)) - ChromaMid;

	always_ff @(posedge clk) begin
		if (en) begin
			luma_first_s1   <= luma_first;
			luma_second_s1  <= luma_second;
			cb_s1           <= chroma_blue;
			cr_s1           <= chroma_red;
			alpha_first_s1  <= alpha_first_in;
			alpha_second_s1 <= alpha_second_in;

			red_term_s2     <= cr_e * CoefRv + Round;
			green_term_s2   <= Round - cb_d * CoefGu - cr_e * CoefGv;
			blue_term_s2    <= cb_d * CoefBu + Round;
			alpha_first_s2  <= alpha_first_s1;
			alpha_second_s2 <= alpha_second_s1;
		end
	end

	yuyv2rgb_lane u_lane_first (
		.clk           (clk),
		.en            (en),
		.luma_s1       (luma_first_s1),
		.red_term_s2   (red_term_s2),
		.green_term_s2 (green_term_s2),
		.blue_term_s2  (blue_term_s2),
		.red           (red_a),
		.green         (green_a),
		.blue          (blue_a)
	);

	yuyv2rgb_lane u_lane_second (
		.clk           (clk),
		.en            (en),
		.luma_s1       (luma_second_s1),
		.red_term_s2   (red_term_s2),
		.green_term_s2 (green_term_s2),
		.blue_term_s2  (blue_term_s2),
		.red           (red_b),
		.green         (green_b),
		.blue          (blue_b)
	);

	yuyv2rgb_addr u_addr (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.fire      (fire),
		.cfg       (cfg_q),
		.offset    (offset_s2),
		.last_pair (last_s2)
	);

	// merge lanes, alpha and address into the output register
	always_ff @(posedge clk) begin
		if (en) begin
			red_first_s3    <= red_a;
			green_first_s3  <= green_a;
			blue_first_s3   <= blue_a;
			red_second_s3   <= red_b;
			green_second_s3 <= green_b;
			blue_second_s3  <= blue_b;
			offset_s3       <= offset_s2;
			frame_end_s3    <= last_s2;
			if (!cfg_q.alpha_out) begin
				alpha_first_s3  <= '0;
				alpha_second_s3 <= '0;
			end else if (cfg_q.alpha_in) begin
				alpha_first_s3  <= alpha_first_s2;
				alpha_second_s3 <= alpha_second_s2;
			end else begin
				alpha_first_s3  <= AlphaOpaque;
				alpha_second_s3 <= AlphaOpaque;
			end
		end
	end

	assign out_valid        = valid_s3;
	assign red_first        = red_first_s3;
	assign green_first      = green_first_s3;
	assign blue_first       = blue_first_s3;
	assign alpha_first_out  = alpha_first_s3;
	assign red_second       = red_second_s3;
	assign green_second     = green_second_s3;
	assign blue_second      = blue_second_s3;
	assign alpha_second_out = alpha_second_s3;
	assign dest_offset      = offset_s3;
	assign frame_end        = frame_end_s3;

endmodule

@@ sim/tb.sv @@
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import yuyv2rgb_pkg::*;

	typedef enum int {
		IdleNone,
		IdleSender,
		IdleReceiver,
		IdleBoth
	} idle_mode_t;

	localparam int StallLimit = 4000;
	localparam int RandomPhases = 12;
	localparam int ItemsPerPhase = 125;

	typedef struct packed {
		logic [PixW-1:0] luma_a;
		logic [PixW-1:0] cb;
		logic [PixW-1:0] luma_b;
		logic [PixW-1:0] cr;
		logic [PixW-1:0] alpha_a;
		logic [PixW-1:0] alpha_b;
	} macropixel_t;

	typedef struct packed {
		logic [PixW-1:0]    r_a;
		logic [PixW-1:0]    g_a;
		logic [PixW-1:0]    b_a;
		logic [PixW-1:0]    al_a;
		logic [PixW-1:0]    r_b;
		logic [PixW-1:0]    g_b;
		logic [PixW-1:0]    b_b;
		logic [PixW-1:0]    al_b;
		logic [OffsetW-1:0] offset;
		logic               last;
	} rgb_pair_t;

	logic                clk;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [PixW-1:0]     luma_first = '0;
	logic [PixW-1:0]     chroma_blue = '0;
	logic [PixW-1:0]     luma_second = '0;
	logic [PixW-1:0]     chroma_red = '0;
	logic [PixW-1:0]     alpha_first_in = '0;
	logic [PixW-1:0]     alpha_second_in = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [PixW-1:0]     red_first;
	logic [PixW-1:0]     green_first;
	logic [PixW-1:0]     blue_first;
	logic [PixW-1:0]     alpha_first_out;
	logic [PixW-1:0]     red_second;
	logic [PixW-1:0]     green_second;
	logic [PixW-1:0]     blue_second;
	logic [PixW-1:0]     alpha_second_out;
	logic [OffsetW-1:0]  dest_offset;
	logic                frame_end;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [CfgIdxW-1:0]  cfg_index = '0;
	logic [CfgW-1:0]     cfg_data = '0;

	// shadow of the frame registers, reset values
	logic [CfgW-1:0] cfg_width = CfgW'(640);
	logic [CfgW-1:0] cfg_height = CfgW'(480);
	logic            cfg_alpha_in = 1'b0;
	logic            cfg_alpha_out = 1'b0;

	int unsigned pair_col;
	int unsigned row_num;

	macropixel_t macropixel_queue[$];
	rgb_pair_t   expected_pairs[$];

	logic        in_fire = 1'b0;
	bit          sender_hold = 1'b0;
	int unsigned sender_idle_pct = 0;
	int unsigned stall_pct = 0;
	int unsigned idle_cycles = 0;
	int unsigned mismatches = 0;
	int unsigned items_sent = 0;
	int unsigned pairs_checked = 0;
	int unsigned frame_ends = 0;
	int unsigned settings_used = 0;

	yuyv_to_rgb_converter_top u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.luma_first       (luma_first),
		.chroma_blue      (chroma_blue),
		.luma_second      (luma_second),
		.chroma_red       (chroma_red),
		.alpha_first_in   (alpha_first_in),
		.alpha_second_in  (alpha_second_in),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.red_first        (red_first),
		.green_first      (green_first),
		.blue_first       (blue_first),
		.alpha_first_out  (alpha_first_out),
		.red_second       (red_second),
		.green_second     (green_second),
		.blue_second      (blue_second),
		.alpha_second_out (alpha_second_out),
		.dest_offset      (dest_offset),
		.frame_end        (frame_end),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic logic [PixW-1:0] clamp_channel8(int v);
		if (v < 0) return '0;
		if ((v >>> 8) > 255) return '1;
		return PixW'(v >>> 8);
	endfunction

	// converts one macropixel and advances the frame position
	function automatic rgb_pair_t convert_macropixel(macropixel_t px);
		rgb_pair_t   res;
		int unsigned w;
		int unsigned h;
		int unsigned pairs;
		int unsigned bpp;
		int          c_a;
		int          c_b;
		int          d;
		int          e;
		w = cfg_width;
		if (w < 2) w = 2;
		if (w > MaxWidth) w = MaxWidth;
		w = w & ~32'd1;
		h = cfg_height;
		if (h < 1) h = 1;
		if (h > MaxHeight) h = MaxHeight;
		pairs = w / 2;
		if (pair_col >= pairs) pair_col = 0;
		if (row_num >= h) row_num = 0;
		d = int'(px.cb) - 128;
		e = int'(px.cr) - 128;
		c_a = int'(px.luma_a) - 16;
		c_b = int'(px.luma_b) - 16;
		res.r_a = clamp_channel8(298 * c_a + 409 * e + 128);
		res.g_a = clamp_channel8(298 * c_a - 100 * d - 208 * e + 128);
		res.b_a = clamp_channel8(298 * c_a + 516 * d + 128);
		res.r_b = clamp_channel8(298 * c_b + 409 * e + 128);
		res.g_b = clamp_channel8(298 * c_b - 100 * d - 208 * e + 128);
		res.b_b = clamp_channel8(298 * c_b + 516 * d + 128);
		if (cfg_alpha_out) begin
			bpp = 4;
			res.al_a = cfg_alpha_in ? px.alpha_a : '1;
			res.al_b = cfg_alpha_in ? px.alpha_b : '1;
		end else begin
			bpp = 3;
			res.al_a = '0;
			res.al_b = '0;
		end
		res.offset = OffsetW'((h - 1 - row_num) * w * bpp + pair_col * 2 * bpp);
		res.last = (pair_col == pairs - 1) && (row_num == h - 1);
		pair_col++;
		if (pair_col >= pairs) begin
			pair_col = 0;
			row_num++;
			if (row_num >= h) row_num = 0;
		end
		return res;
	endfunction

	task automatic check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s expected %0d actual %0d", name, want, got);
			mismatches++;
		end
	endtask

	// input driver, also drives the random out_stall
	always @(negedge clk or negedge arst_n) begin : drive_input
		macropixel_t item;
		if (!arst_n) begin
			in_valid <= 1'b0;
			out_stall <= 1'b0;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
			if (!in_valid || in_fire) begin
				if (macropixel_queue.size() != 0 && !sender_hold &&
				    $urandom_range(99) >= sender_idle_pct) begin
					item = macropixel_queue.pop_front();
					in_valid <= 1'b1;
					luma_first <= item.luma_a;
					chroma_blue <= item.cb;
					luma_second <= item.luma_b;
					chroma_red <= item.cr;
					alpha_first_in <= item.alpha_a;
					alpha_second_in <= item.alpha_b;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: predicts on input transfers, checks output transfers, ends the run if transfers stop
	always @(posedge clk or negedge arst_n) begin : monitor
		rgb_pair_t want;
		if (!arst_n) begin
			in_fire <= 1'b0;
			pair_col = 0;
			row_num = 0;
			idle_cycles = 0;
		end else begin
			in_fire <= in_valid && !in_stall;
			if (out_valid && !out_stall) begin
				if (expected_pairs.size() == 0) begin
					$error("unexpected rgb pair at offset %0d", dest_offset);
					mismatches++;
				end else begin
					want = expected_pairs.pop_front();
					check_field("red_first", want.r_a, red_first);
					check_field("green_first", want.g_a, green_first);
					check_field("blue_first", want.b_a, blue_first);
					check_field("alpha_first_out", want.al_a, alpha_first_out);
					check_field("red_second", want.r_b, red_second);
					check_field("green_second", want.g_b, green_second);
					check_field("blue_second", want.b_b, blue_second);
					check_field("alpha_second_out", want.al_b, alpha_second_out);
					check_field("dest_offset", want.offset, dest_offset);
					check_field("frame_end", want.last, frame_end);
					pairs_checked++;
					if (frame_end) frame_ends++;
				end
			end
			if (in_valid && !in_stall) begin
				expected_pairs.push_back(convert_macropixel({luma_first, chroma_blue,
					luma_second, chroma_red, alpha_first_in, alpha_second_in}));
				items_sent++;
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
			    (cfg_valid && cfg_ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= StallLimit) begin
				$display("no transfer for %0d cycles", StallLimit);
				$display("tb: FAIL");
				$finish;
			end
		end
	end

	task automatic write_reg(logic [CfgIdxW-1:0] idx, int unsigned val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CfgW'(val);
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			RegFrameWidth:  cfg_width = CfgW'(val);
			RegFrameHeight: cfg_height = CfgW'(val);
			RegAlphaIn:     cfg_alpha_in = val[0];
			RegAlphaOut:    cfg_alpha_out = val[0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic apply_frame(int unsigned w, int unsigned h, bit ain, bit aout, bit partial);
		if (!partial || $urandom_range(3) != 0) write_reg(RegFrameWidth, w);
		if (!partial || $urandom_range(3) != 0) write_reg(RegFrameHeight, h);
		if (!partial || $urandom_range(3) != 0) write_reg(RegAlphaIn, ain);
		if (!partial || $urandom_range(3) != 0) write_reg(RegAlphaOut, aout);
		settings_used++;
	endtask

	task automatic wait_idle();
		while (macropixel_queue.size() != 0 || in_valid || expected_pairs.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [PixW-1:0] pick_byte();
		case ($urandom_range(15))
			0: return '0;
			1: return '1;
			2: return PixW'(16);
			3: return PixW'(128);
			default: return PixW'($urandom);
		endcase
	endfunction

	task automatic push_item(int unsigned la, int unsigned cb, int unsigned lb,
	                         int unsigned cr, int unsigned aa, int unsigned ab);
		macropixel_t px;
		px = {PixW'(la), PixW'(cb), PixW'(lb), PixW'(cr), PixW'(aa), PixW'(ab)};
		macropixel_queue.push_back(px);
	endtask

	task automatic run_phase(int n, idle_mode_t mode);
		sender_idle_pct = (mode == IdleSender) ? 84 : (mode == IdleBoth) ? 6 : 0;
		stall_pct = (mode == IdleReceiver) ? 84 : (mode == IdleBoth) ? 6 : 0;
		repeat (n) begin
			push_item(pick_byte(), pick_byte(), pick_byte(), pick_byte(),
			          pick_byte(), pick_byte());
		end
		if (n >= 20) begin
			// hold the sender mid-phase until the pipeline has drained
			while (macropixel_queue.size() > n / 2) @(posedge clk);
			sender_hold = 1'b1;
			while (in_valid || expected_pairs.size() != 0) @(posedge clk);
			repeat ($urandom_range(1, 6)) @(posedge clk);
			sender_hold = 1'b0;
		end
		wait_idle();
	endtask

	function automatic int unsigned pick_size(int unsigned lo_max, int unsigned mid_max);
		int unsigned sel;
		sel = $urandom_range(9);
		if (sel < 7) return $urandom_range(0, lo_max);
		if (sel < 9) return $urandom_range(lo_max + 1, mid_max);
		return $urandom_range(mid_max + 1, (1 << CfgW) - 1);
	endfunction

	initial begin : stimulus
		idle_mode_t mode;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// default frame: color extremes, black and white, ignored alpha bytes
		push_item(0, 0, 255, 0, 8'h00, 8'hFF);
		push_item(255, 0, 0, 255, 8'hA5, 8'h5A);
		push_item(0, 255, 255, 255, 8'hFF, 8'h00);
		push_item(255, 255, 0, 0, 8'h5A, 8'hA5);
		push_item(16, 128, 235, 128, 8'h01, 8'h80);
		push_item(235, 0, 16, 255, 8'h80, 8'h01);
		push_item(255, 128, 0, 128, 8'h7F, 8'hFE);
		push_item(128, 255, 128, 0, 8'hFE, 8'h7F);
		push_item(16, 0, 16, 0, 8'h00, 8'h00);
		push_item(255, 255, 255, 255, 8'hFF, 8'hFF);
		settings_used++;
		run_phase(0, IdleNone);

		// smallest frame, opaque alpha out
		apply_frame(2, 1, 1'b0, 1'b1, 1'b0);
		run_phase(3, IdleNone);
		// sizes below range
		apply_frame(0, 0, 1'b1, 1'b1, 1'b0);
		run_phase(3, IdleNone);
		// sizes above range, alpha in ignored
		apply_frame(8191, 8191, 1'b1, 1'b0, 1'b0);
		run_phase(3, IdleNone);
		// largest frame with passed alpha
		apply_frame(4096, 4096, 1'b1, 1'b1, 1'b0);
		run_phase(3, IdleNone);
		// unused register index must change nothing
		write_reg(CfgIdxW'($urandom_range(int'(RegAlphaOut) + 1, (1 << CfgIdxW) - 1)),
		          $urandom);
		// odd width, column beyond the new frame
		apply_frame(7, 3, 1'b0, 1'b0, 1'b0);
		run_phase(5, IdleNone);
		// column beyond the new frame
		apply_frame(2, 8, 1'b0, 1'b1, 1'b0);
		run_phase(5, IdleNone);
		apply_frame(4, 3, 1'b1, 1'b1, 1'b0);
		run_phase(3, IdleNone);

		for (int p = 0; p < RandomPhases; p++) begin
			mode = idle_mode_t'(p % 4);
			apply_frame(pick_size(40, 1000), pick_size(6, 100), $urandom_range(1),
			            $urandom_range(1), (p % 3) == 2);
			if ($urandom_range(3) == 0)
				write_reg(CfgIdxW'($urandom_range(int'(RegAlphaOut) + 1,
				          (1 << CfgIdxW) - 1)), $urandom);
			run_phase(ItemsPerPhase, mode);
		end

		sender_idle_pct = 0;
		stall_pct = 0;
		wait_idle();
		repeat (10) @(posedge clk);
		$display("tb: %0d macropixels sent, %0d rgb pairs checked over %0d frame settings",
		         items_sent, pairs_checked, settings_used);
		$display("tb: %0d frame ends seen, %0d mismatches", frame_ends, mismatches);
		if (mismatches == 0) begin
			$display("tb: PASS");
		end else begin
			$display("tb: FAIL");
		end
		$finish;
	end

endmodule
